// ===== rtl/wildcard_star_regex_matcher_defines.svh =====
// ---------------------------------------------------------------------------
// wildcard_star_regex_matcher_defines
// Assertion macros for the dot-star matcher; empty when synthesizing.
// ---------------------------------------------------------------------------
`ifndef WILDCARD_STAR_REGEX_MATCHER_DEFINES_SVH
`define WILDCARD_STAR_REGEX_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WSRM_ASSERT_SAME(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define WSRM_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);
`else
`define WSRM_ASSERT_SAME(lbl, ant, cons, msg)
`define WSRM_ASSERT_NEXT(lbl, ant, cons, msg)
`endif

`endif

// ===== rtl/wsrm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsrm_pkg
// Shared types and constants of the dot-star matcher.
// ---------------------------------------------------------------------------
package wsrm_pkg;

  localparam int SEG_CELLS   = 8;
  localparam int CFG_W       = 6;
  localparam int OP_W        = 2;
  localparam int TOK_IDX_W   = 5;
  localparam int BYTE_W      = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  // in_tdata field positions
  localparam int IDX_LSB   = 0;
  localparam int TBYTE_LSB = 5;
  localparam int ANY_BIT   = 13;
  localparam int REP_BIT   = 14;
  localparam int TEXT_LSB  = 15;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TEXT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              first;
    logic              start;
    logic              prop;
    logic [BYTE_W-1:0] text_byte;
  } cell_ctl_t;

endpackage

// ===== rtl/wsrm_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsrm_cell
// One pattern token and its prefix-match bit, with the closure carry link.
// ---------------------------------------------------------------------------
module wsrm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wsrm_pkg::cell_ctl_t       ctl,
  input  logic                      tok_we,
  input  logic [wsrm_pkg::BYTE_W-1:0] tok_byte,
  input  logic                      tok_any,
  input  logic                      tok_rep,
  input  logic                      left_bit,
  input  logic                      carry_in,
  output logic                      own_bit,
  output logic                      base_bit,
  output logic                      carry_out
);

  logic [wsrm_pkg::BYTE_W-1:0] byte_r;
  logic                        any_r;
  logic                        rep_r;
  logic                        own_r;
  logic                        own_nxt;
  logic                        hit;

  always_ff @(posedge clk) begin
    if (tok_we) begin
      byte_r <= tok_byte;
      any_r  <= tok_any;
      rep_r  <= tok_rep;
    end
  end

  always_comb begin
    hit = any_r | (byte_r == ctl.text_byte);
    if (ctl.first) begin
      if (ctl.start) begin
        base_bit = 1'b0;
      end else if (rep_r) begin
        base_bit = own_r & hit;
      end else begin
        base_bit = left_bit & hit;
      end
    end else begin
      base_bit = own_r;
    end
    // starred token passes the left neighbor's match on
    carry_out = base_bit | (rep_r & carry_in);
    own_nxt   = (ctl.first || ctl.prop) ? carry_out : own_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r <= 1'b0;
    end else begin
      own_r <= own_nxt;
    end
  end

  assign own_bit = own_r;

endmodule

// ===== rtl/wsrm_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsrm_ctrl
// Beat sequencer: decodes the op, counts closure passes, holds the result.
// ---------------------------------------------------------------------------
module wsrm_ctrl #(
  parameter int NUM_PASSES = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  wsrm_pkg::op_t               in_op,
  input  logic [wsrm_pkg::BYTE_W-1:0] in_text_byte,
  input  logic                        matched,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic                        out_matched,
  output wsrm_pkg::cell_ctl_t         ctl
);

  localparam int CW = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;

  wsrm_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    pass_r, pass_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_matched_r;
  logic             out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wsrm_pkg::ST_IDLE;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_matched_r <= matched;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    in_tready     = 1'b0;
    out_load      = 1'b0;
    ctl           = '0;
    ctl.text_byte = in_text_byte;
    case (state_r)
      wsrm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_op)
            wsrm_pkg::OP_LOAD: begin
              ctl.load = 1'b1;
            end
            wsrm_pkg::OP_START: begin
              ctl.first = 1'b1;
              ctl.start = 1'b1;
            end
            wsrm_pkg::OP_TEXT: begin
              ctl.first = 1'b1;
            end
            default: ;
          endcase
          if (ctl.first && (NUM_PASSES > 1)) begin
            state_nxt = wsrm_pkg::ST_RUN;
            pass_nxt  = CW'(NUM_PASSES - 1);
          end else begin
            state_nxt = wsrm_pkg::ST_WAIT;
          end
        end
      end
      wsrm_pkg::ST_RUN: begin
        ctl.prop = 1'b1;
        if (pass_r == CW'(1)) begin
          state_nxt = wsrm_pkg::ST_WAIT;
        end else begin
          pass_nxt = pass_r - CW'(1);
        end
      end
      wsrm_pkg::ST_WAIT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = wsrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wsrm_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load | (out_valid_r & ~out_tready);
  end

  assign out_tvalid  = out_valid_r;
  assign out_matched = out_matched_r;

endmodule

// ===== rtl/wildcard_star_regex_matcher.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_star_regex_matcher
// Dot-star pattern matcher over a row of token cells.
// ---------------------------------------------------------------------------
// Sequence: a start or text beat runs one closure pass per group of 8 cells,
// the first as it is taken and the rest in ST_RUN; a token load or unused op
// skips them. Each beat then waits in ST_WAIT until the result register is
// free, and no new beat is taken before its result is loaded.
// Reset: match row holds only bit 0, pattern_length is 0, token store is
// undefined until loaded.
`include "wildcard_star_regex_matcher_defines.svh"

module wildcard_star_regex_matcher #(
  parameter int MAX_TOKENS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [wsrm_pkg::CFG_W-1:0]           cfg_wr_data,  // pattern_length
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // token_index, token_byte, token_any, token_repeat, text_byte, pad
  input  logic [wsrm_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [wsrm_pkg::OP_W-1:0]            in_tuser,     // op
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [wsrm_pkg::OUT_TDATA_W-1:0]     out_tdata     // matched, pad
);

  localparam int NUM_PASSES = (MAX_TOKENS + wsrm_pkg::SEG_CELLS - 1) / wsrm_pkg::SEG_CELLS;
  localparam int RW = $clog2(MAX_TOKENS + 1);
  localparam int LW = (RW > wsrm_pkg::CFG_W) ? RW : wsrm_pkg::CFG_W;

  wsrm_pkg::cell_ctl_t ctl;

  logic [wsrm_pkg::CFG_W-1:0] cfg_len_r;
  logic [LW-1:0]              len_ext;
  logic [LW-1:0]              used_len;
  logic                       row0_r, row0_nxt;
  logic [MAX_TOKENS:0]        row;
  logic [MAX_TOKENS-1:0]      own_bits;
  logic [MAX_TOKENS-1:0]      base_bits;
  logic [MAX_TOKENS-1:0]      carry_in;
  logic [MAX_TOKENS-1:0]      carry_out;
  logic [MAX_TOKENS-1:0]      tok_we;
  logic                       matched;
  logic                       out_matched;

  logic [wsrm_pkg::TOK_IDX_W-1:0] tok_idx;
  logic [wsrm_pkg::BYTE_W-1:0]    tok_byte;
  logic [wsrm_pkg::BYTE_W-1:0]    text_byte;

  assign tok_idx   = in_tdata[wsrm_pkg::IDX_LSB +: wsrm_pkg::TOK_IDX_W];
  assign tok_byte  = in_tdata[wsrm_pkg::TBYTE_LSB +: wsrm_pkg::BYTE_W];
  assign text_byte = in_tdata[wsrm_pkg::TEXT_LSB +: wsrm_pkg::BYTE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= '0;
      row0_r    <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
      row0_r <= row0_nxt;
    end
  end

  // row bit 0 is set only for empty text
  assign row0_nxt = ctl.first ? ctl.start : row0_r;

  wsrm_ctrl #(
    .NUM_PASSES (NUM_PASSES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_op        (wsrm_pkg::op_t'(in_tuser)),
    .in_text_byte (text_byte),
    .matched      (matched),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_matched  (out_matched),
    .ctl          (ctl)
  );

  assign row[0] = row0_r;

  for (genvar j = 0; j < MAX_TOKENS; j++) begin : g_cell
    assign row[j+1]  = own_bits[j];
    assign tok_we[j] = ctl.load && ({{(32 - wsrm_pkg::TOK_IDX_W){1'b0}}, tok_idx} == 32'(j));

    // group heads take a registered carry in ST_RUN, the rest chain in-group
    if (j == 0) begin : g_head0
      assign carry_in[j] = ctl.first ? ctl.start : row0_r;
    end else if ((j % wsrm_pkg::SEG_CELLS) == 0) begin : g_head
      assign carry_in[j] = ctl.first ? base_bits[j-1] : row[j];
    end else begin : g_link
      assign carry_in[j] = carry_out[j-1];
    end

    wsrm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .tok_we    (tok_we[j]),
      .tok_byte  (tok_byte),
      .tok_any   (in_tdata[wsrm_pkg::ANY_BIT]),
      .tok_rep   (in_tdata[wsrm_pkg::REP_BIT]),
      .left_bit  (row[j]),
      .carry_in  (carry_in[j]),
      .own_bit   (own_bits[j]),
      .base_bit  (base_bits[j]),
      .carry_out (carry_out[j])
    );
  end

  // length beyond the row saturates to the last position
  assign len_ext  = LW'(cfg_len_r);
  assign used_len = (len_ext > LW'(MAX_TOKENS)) ? LW'(MAX_TOKENS) : len_ext;
  assign matched  = row[used_len[RW-1:0]];

  assign out_tdata = {{(wsrm_pkg::OUT_TDATA_W - 1){1'b0}}, out_matched};

  `WSRM_ASSERT_NEXT(a_text_clears_row0, ctl.first && !ctl.start, !row0_r, "text kept row bit 0")
  `WSRM_ASSERT_NEXT(a_start_sets_row0, ctl.first && ctl.start, row0_r, "start cleared row bit 0")
  `WSRM_ASSERT_NEXT(a_prop_monotone, ctl.prop, (row & $past(row)) == $past(row), "row bit dropped")
  `WSRM_ASSERT_SAME(a_no_accept_in_pass, ctl.prop, !(in_tvalid && in_tready), "accept in pass")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dot-star matcher. A built-in model of the
// match row predicts the matched bit of every accepted beat. Stimulus is a
// directed table of edge cases, followed by random patterns with texts
// derived from them. Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
  import wsrm_pkg::*;

  localparam int NTOK       = 32;
  localparam int ITEM_GOAL  = 1150;
  localparam int IDLE_LIMIT = 2000;

  typedef struct {
    int          new_len;   // -1: keep pattern_length
    op_t         op;
    logic [4:0]  idx;
    logic [7:0]  tbyte;
    bit          tany;
    bit          trep;
    logic [7:0]  text;
    int          want;      // -1: take the model's answer
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // pattern store and match row as the block should hold them
  bit [7:0]    tok_byte [NTOK];
  bit          tok_any  [NTOK];
  bit          tok_rep  [NTOK];
  bit [NTOK:0] match_row;
  bit [5:0]    cur_len;

  bit       matched_q[$];
  int       err_count = 0;
  int       items_sent = 0;
  bit       quiet_phase = 1'b0;
  int       rx_hold = 0;
  int       idle_cycles = 0;
  bit       rx_want;
  dir_row_t dir_tab[25];

  wildcard_star_regex_matcher uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit advance_matcher(op_t op, bit [4:0] idx, bit [7:0] tbyte,
                                         bit tany, bit trep, bit [7:0] text);
    bit [NTOK:0] nxt;
    bit          hit;
    case (op)
      OP_LOAD: begin
        tok_byte[idx] = tbyte;
        tok_any[idx]  = tany;
        tok_rep[idx]  = trep;
      end
      OP_START: begin
        match_row[0] = 1'b1;
        for (int j = 0; j < NTOK; j++) match_row[j+1] = match_row[j] & tok_rep[j];
      end
      OP_TEXT: begin
        nxt = '0;
        for (int j = 0; j < NTOK; j++) begin
          hit = tok_any[j] || (tok_byte[j] == text);
          if (tok_rep[j]) nxt[j+1] = nxt[j] | (match_row[j+1] & hit);
          else nxt[j+1] = match_row[j] & hit;
        end
        match_row = nxt;
      end
      default: ;
    endcase
    return match_row[(cur_len > NTOK) ? NTOK : cur_len];
  endfunction

  // mostly a tiny alphabet so that texts hit the pattern often
  function automatic bit [7:0] pick_byte();
    bit [7:0] b;
    if ($urandom_range(0, 3) != 0) b = 8'h61 + 8'($urandom_range(0, 2));
    else b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic push_beat(op_t op, bit [4:0] idx, bit [7:0] tbyte, bit tany, bit trep,
                           bit [7:0] text, int want);
    int gap;
    bit pred;
    gap = quiet_phase ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, text, trep, tany, tbyte, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = advance_matcher(op, idx, tbyte, tany, trep, text);
    matched_q.push_back((want < 0) ? pred : want[0]);
    items_sent++;
  endtask

  task automatic send_plain(op_t op, bit [7:0] text);
    push_beat(op, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), text, -1);
  endtask

  task automatic load_token(int k);
    push_beat(OP_LOAD, 5'(k), pick_byte(), ($urandom_range(0, 4) == 0),
              ($urandom_range(0, 2) == 0), 8'($urandom_range(0, 255)), -1);
  endtask

  // register writes only once the block has handed back every beat
  task automatic set_length(int len);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (matched_q.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 6'(len);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_len = 6'(len);
  endtask

  // result side: check every beat, then maybe hold tready low a while
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (matched_q.size() == 0) begin
          $error("result beat with nothing expected, matched=%0d", out_tdata[0]);
          err_count++;
        end else begin
          rx_want = matched_q.pop_front();
          if (out_tdata[0] !== rx_want) begin
            $error("matched: expected %0d, actual %0d", rx_want, out_tdata[0]);
            err_count++;
          end
        end
        rx_hold = quiet_phase ? 0 : $urandom_range(0, 8);
      end
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    int len;
    int eff;
    int r;
    int cnt;
    bit [7:0] b;

    dir_tab = '{
      '{-1, OP_NONE,  5'd0,  8'h00, 0, 0, 8'h00,  1},  // no start yet, empty pattern
      '{-1, OP_TEXT,  5'd31, 8'hFF, 1, 1, 8'h00,  0},  // any byte kills the empty match
      '{ 0, OP_START, 5'd0,  8'h00, 0, 0, 8'hFF,  1},
      '{-1, OP_LOAD,  5'd0,  8'h61, 0, 0, 8'h00, -1},  // pattern a.*b\xff*\x00
      '{-1, OP_LOAD,  5'd1,  8'h00, 1, 1, 8'hFF, -1},
      '{-1, OP_LOAD,  5'd2,  8'h62, 0, 0, 8'h00, -1},
      '{-1, OP_LOAD,  5'd3,  8'hFF, 0, 1, 8'h00, -1},
      '{-1, OP_LOAD,  5'd4,  8'h00, 0, 0, 8'hFF, -1},
      '{-1, OP_LOAD,  5'd31, 8'hFF, 1, 1, 8'hFF, -1},
      '{ 3, OP_START, 5'd0,  8'h00, 0, 0, 8'h00, -1},
      '{-1, OP_TEXT,  5'd0,  8'h00, 0, 0, 8'h61, -1},
      '{-1, OP_TEXT,  5'd0,  8'h00, 0, 0, 8'h78, -1},
      '{-1, OP_TEXT,  5'd0,  8'h00, 0, 0, 8'h62, -1},
      '{-1, OP_TEXT,  5'd0,  8'h00, 0, 0, 8'h62, -1},
      '{ 4, OP_NONE,  5'd31, 8'hFF, 1, 1, 8'hFF, -1},  // longer length on old text
      '{-1, OP_TEXT,  5'd0,  8'h00, 0, 0, 8'hFF, -1},
      '{-1, OP_TEXT,  5'd0,  8'h00, 0, 0, 8'h00, -1},
      '{ 5, OP_NONE,  5'd0,  8'h00, 0, 0, 8'h00, -1},
      '{32, OP_START, 5'd0,  8'h00, 0, 0, 8'h00, -1},
      '{-1, OP_TEXT,  5'd0,  8'h00, 0, 0, 8'hFF, -1},
      '{63, OP_START, 5'd0,  8'h00, 0, 0, 8'h00, -1},  // saturates to full length
      '{-1, OP_TEXT,  5'd0,  8'h00, 0, 0, 8'h00, -1},
      '{40, OP_LOAD,  5'd0,  8'hFF, 1, 1, 8'hFF, -1},
      '{-1, OP_START, 5'd0,  8'h00, 0, 0, 8'h00, -1},
      '{-1, OP_TEXT,  5'd31, 8'hFF, 1, 1, 8'hFF, -1}
    };

    match_row = 1;
    cur_len   = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole token store first so no row bit ever sees an unloaded token
    for (int k = 0; k < NTOK; k++) load_token(k);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].new_len >= 0) set_length(dir_tab[i].new_len);
      push_beat(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].tbyte, dir_tab[i].tany,
                dir_tab[i].trep, dir_tab[i].text, dir_tab[i].want);
    end

    while (items_sent < ITEM_GOAL) begin
      r = $urandom_range(0, 19);
      if (r < 13) len = $urandom_range(0, 8);
      else if (r < 16) len = $urandom_range(9, 32);
      else if (r == 16) len = 0;
      else if (r == 17) len = 32;
      else if (r == 18) len = 63;
      else len = $urandom_range(33, 62);
      set_length(len);
      quiet_phase = ($urandom_range(0, 3) == 0);
      eff = (len > NTOK) ? NTOK : len;

      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 4) != 0) begin
          for (int k = 0; k < eff; k++) begin
            if ($urandom_range(0, 2) != 0) load_token(k);
          end
        end
        if ($urandom_range(0, 7) != 0) send_plain(OP_START, 8'($urandom_range(0, 255)));

        // text that walks the pattern, with the odd wrong byte and stray beat
        for (int k = 0; k < eff; k++) begin
          cnt = tok_rep[k] ? $urandom_range(0, 3) : 1;
          repeat (cnt) begin
            b = tok_any[k] ? pick_byte() : tok_byte[k];
            if ($urandom_range(0, 9) == 0) b = pick_byte();
            send_plain(OP_TEXT, b);
            if ($urandom_range(0, 15) == 0) begin
              if ($urandom_range(0, 1) == 0) send_plain(OP_NONE, 8'($urandom_range(0, 255)));
              else load_token($urandom_range(0, NTOK - 1));
            end
          end
        end
        repeat ($urandom_range(0, 2)) send_plain(OP_TEXT, pick_byte());
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (matched_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (matched_q.size() != 0) begin
      $error("%0d expected results never arrived", matched_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
